### rtl/rc4kb_pkg.sv
package rc4kb_pkg;

   localparam int BOX_SIZE      = 256;
   localparam int BOX_AW        = 8;
   localparam int KEY_DEPTH_DEF = 256;

   // tuser codes on the request side
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_D_A,
      S_D_B,
      S_D_K,
      S_K_RD,
      S_K_SUM,
      S_K_W1,
      S_K_W2
   } state_type;

   // control group from sequencer to box store
   typedef struct packed {
      logic              clear;
      logic              re;
      logic [BOX_AW-1:0] raddr;
      logic              we;
      logic [BOX_AW-1:0] waddr;
      logic [7:0]        wdata;
   } box_ctl_type;

   // the shared byte adder
   function automatic logic [7:0] add3(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] z);
      add3 = x + y + z;
   endfunction

endpackage

### rtl/rc4kb_box.sv
module rc4kb_box
   import rc4kb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  box_ctl_type ctl,
   output logic [7:0]  rd_data
);

   logic [7:0]          mem [BOX_SIZE];
   logic [BOX_SIZE-1:0] vld_ff;
   logic [7:0]          mem_q_ff;
   logic                vld_q_ff;
   logic [BOX_AW-1:0]   addr_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         mem_q_ff  <= mem[ctl.raddr];
         addr_q_ff <= ctl.raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (ctl.clear) begin
            vld_ff <= '0;
         end else if (ctl.we) begin
            vld_ff[ctl.waddr] <= 1'b1;
         end
         if (ctl.re) begin
            vld_q_ff <= vld_ff[ctl.raddr];
         end
      end
   end

   // unwritten entry reads as identity
   assign rd_data = vld_q_ff ? mem_q_ff : addr_q_ff;

endmodule

### rtl/rc4_variant_keybox_stream_decrypt.sv
// Channel  Dir  Fields (tdata/tuser low bit up)            Handshake
// req      in   tdata: value[7:0]; tuser: op; tlast: last   req_tvalid/req_tready
// rsp      out  tdata: plain_byte[7:0]                      rsp_tvalid/rsp_tready
//
// Key item: taken in S_IDLE. Key item with last: the schedule then runs S_K_RD, S_K_SUM,
// S_K_W1, S_K_W2 for each of 256 entries (read box[i] with key byte, sum and read box[c],
// two writes on the one box write port). Data item: three dependent box reads through the
// registered read port. One 8-bit adder serves every box-index sum. Reset is synchronous;
// the box reads as the identity at once through per-entry valid bits, no clearing pass.
// req_tready is high only when the sequencer is idle; a waiting result does not block
// acceptance, only the final state (S_D_K) of the next data item.
module rc4_variant_keybox_stream_decrypt
   import rc4kb_pkg::*;
#(
   parameter int KEY_DEPTH = KEY_DEPTH_DEF
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // value[7:0]
   input  logic       req_tuser,   // op
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // plain_byte[7:0]
);

   localparam int KCW = $clog2(KEY_DEPTH + 1);
   localparam int KIW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   state_type         state_ff, state_in;
   logic [7:0]        pos_ff, pos_in;
   logic [KCW-1:0]    cnt_ff, cnt_in;
   logic [KIW-1:0]    koff_ff, koff_in;
   logic [7:0]        idx_ff, idx_in;
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        held_ff, held_in;
   logic [7:0]        c_ff, c_in;
   logic [7:0]        a_ff, a_in;
   logic [7:0]        val_ff, val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   logic [7:0]        key_mem [KEY_DEPTH];
   logic [7:0]        key_q_ff;
   logic              key_we, key_re;

   box_ctl_type       box_ctl;
   logic [7:0]        box_rd;

   logic [7:0]        add_x, add_y, add_z, add_sum;
   logic [KCW-1:0]    koff_nxt;
   logic              accept;

   rc4kb_box u_box (
      .clock   (clock),
      .reset   (reset),
      .ctl     (box_ctl),
      .rd_data (box_rd)
   );

   // key store: written at the fill index, read at the cycled key offset
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[cnt_ff[KIW-1:0]] <= req_tdata;
      end
      if (key_re) begin
         key_q_ff <= key_mem[koff_ff];
      end
   end

   assign add_sum  = add3(add_x, add_y, add_z);
   assign koff_nxt = KCW'(koff_ff) + KCW'(1);
   assign accept   = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= 8'd1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      koff_ff     <= koff_in;
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      held_ff     <= held_in;
      c_ff        <= c_in;
      a_ff        <= a_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      koff_in      = koff_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      c_in         = c_ff;
      a_in         = a_ff;
      val_in       = val_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      key_we       = 1'b0;
      key_re       = 1'b0;
      box_ctl      = '0;
      add_x        = box_rd;
      add_y        = pos_ff;
      add_z        = 8'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_DATA) begin
                  val_in        = req_tdata;
                  box_ctl.re    = 1'b1;
                  box_ctl.raddr = pos_ff;
                  state_in      = S_D_A;
               end else begin
                  if (cnt_ff < KCW'(KEY_DEPTH)) begin
                     key_we = 1'b1;
                     cnt_in = cnt_ff + KCW'(1);
                  end
                  if (req_tlast) begin
                     // schedule restarts from the identity box
                     box_ctl.clear = 1'b1;
                     idx_in        = 8'd0;
                     prev_in       = 8'd0;
                     koff_in       = '0;
                     state_in      = S_K_RD;
                  end
               end
            end
         end
         S_D_A: begin
            // a = box[j]; next read box[a + j]
            a_in          = box_rd;
            box_ctl.re    = 1'b1;
            box_ctl.raddr = add_sum;
            state_in      = S_D_B;
         end
         S_D_B: begin
            // b arrived; next read box[a + b]
            add_x         = a_ff;
            add_y         = box_rd;
            box_ctl.re    = 1'b1;
            box_ctl.raddr = add_sum;
            state_in      = S_D_K;
         end
         S_D_K: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = val_ff ^ box_rd;
               pos_in       = pos_ff + 8'd1;
               state_in     = S_IDLE;
            end
         end
         S_K_RD: begin
            box_ctl.re    = 1'b1;
            box_ctl.raddr = idx_ff;
            key_re        = 1'b1;
            state_in      = S_K_SUM;
         end
         S_K_SUM: begin
            // c = box[i] + prev + key byte
            add_x         = box_rd;
            add_y         = prev_ff;
            add_z         = key_q_ff;
            held_in       = box_rd;
            c_in          = add_sum;
            box_ctl.re    = 1'b1;
            box_ctl.raddr = add_sum;
            koff_in       = (koff_nxt >= cnt_ff) ? '0 : koff_nxt[KIW-1:0];
            state_in      = S_K_W1;
         end
         S_K_W1: begin
            box_ctl.we    = 1'b1;
            box_ctl.waddr = idx_ff;
            box_ctl.wdata = box_rd;
            state_in      = S_K_W2;
         end
         S_K_W2: begin
            // written second so c == i leaves the held value
            box_ctl.we    = 1'b1;
            box_ctl.waddr = c_ff;
            box_ctl.wdata = held_ff;
            prev_in       = c_ff;
            idx_in        = idx_ff + 8'd1;
            if (idx_ff == 8'hff) begin
               pos_in   = 8'd1;
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               state_in = S_K_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rc4kb_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS = 850;
   localparam int HOLD_CYCLES  = 300;      // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES = 1200;     // covers a key schedule and more
   localparam int MAX_REPORTS  = 10;
   localparam longint LIMIT_NS = 5_000_000;

   // Expected plaintext tracker: its own copy of key store, box and stream position.
   class decrypt_scoreboard;
      bit [7:0] key_bytes [KEY_DEPTH_DEF];
      bit [8:0] key_len;
      bit [7:0] sbox [BOX_SIZE];
      bit [7:0] pos;
      bit [7:0] plain_expected [$];
      int       failures;
      int       checked;
      int       schedules;
      int       key_items;
      int       data_items;
      int       dropped_keys;

      function new();
         for (int i = 0; i < BOX_SIZE; i++) sbox[i] = 8'(i);
         for (int i = 0; i < KEY_DEPTH_DEF; i++) key_bytes[i] = 8'h00;
         key_len = '0;
         pos     = 8'd1;
      endfunction

      // identity box, then 256 swap steps driven by the running sum
      function void run_key_schedule();
         bit [7:0] sum;
         bit [7:0] held;
         int       koff;
         sum  = 8'h00;
         koff = 0;
         for (int i = 0; i < BOX_SIZE; i++) sbox[i] = 8'(i);
         for (int i = 0; i < BOX_SIZE; i++) begin
            held = sbox[i];
            sum  = held + sum + key_bytes[koff];
            koff++;
            if (koff >= key_len) koff = 0;
            sbox[i]   = sbox[sum];
            sbox[sum] = held;
         end
         pos     = 8'd1;
         key_len = '0;
         schedules++;
      endfunction

      function void note_request(bit op, bit [7:0] value, bit lst);
         bit [7:0] a;
         bit [7:0] b;
         bit [7:0] ks;
         bit [7:0] ia;
         bit [7:0] ib;
         if (op == OP_KEY) begin
            key_items++;
            if (key_len < KEY_DEPTH_DEF) begin
               key_bytes[key_len[7:0]] = value;
               key_len++;
            end else begin
               dropped_keys++;
            end
            if (lst) run_key_schedule();
         end else begin
            // last is don't-care on data
            data_items++;
            a  = sbox[pos];
            ia = a + pos;
            b  = sbox[ia];
            ib = a + b;
            ks = sbox[ib];
            plain_expected.push_back(value ^ ks);
            pos++;
         end
      endfunction

      function void report(string what, bit [7:0] want, bit [7:0] got);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
      endfunction

      function void check_plain(bit [7:0] got);
         bit [7:0] want;
         if (plain_expected.size() == 0) begin
            report("result with nothing pending", 8'h00, got);
         end else begin
            want = plain_expected.pop_front();
            checked++;
            if (got !== want) report("plain_byte mismatch", want, got);
         end
      endfunction

      function int pending();
         return plain_expected.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // value[7:0]
   logic       req_tuser  = OP_KEY;  // op
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // plain_byte[7:0]

   decrypt_scoreboard sb;
   int items_sent   = 0;
   int results_seen = 0;

   rc4_variant_keybox_stream_decrypt dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Entered and left at a falling edge. With no gap, tvalid stays high into
   // the next item, so it is never dropped and raised in the same step.
   task automatic send_item(bit op, bit [7:0] val, bit lst, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, val, lst);
      items_sent++;
      @(negedge clock);
   endtask

   // key bytes with last on the final one; schedule runs on that item
   task automatic send_key(int len, bit no_gap);
      for (int k = 0; k < len; k++)
         send_item(OP_KEY, 8'($urandom), k == len - 1, no_gap);
   endtask

   // data bytes, last set at random (ignored by the block)
   task automatic send_data(int len, bit no_gap);
      for (int k = 0; k < len; k++)
         send_item(OP_DATA, 8'($urandom), 1'($urandom), no_gap);
   endtask

   // hard stop if handshakes hang
   initial begin
      #(LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: random stalls per item, bursts with no stall, and two long
   // hold-offs so the block backs up and drops req_tready.
   initial begin : rsp_side
      int stall;
      bit rsp_burst;
      rsp_burst = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (results_seen == 60 || results_seen == 400) stall = HOLD_CYCLES;
         else stall = rsp_burst ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_plain(rsp_tdata);
         results_seen++;
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         @(negedge clock);
      end
   end

   initial begin : req_side
      int  random_start;
      int  pick;
      bit  burst;
      bit  overflow_done;
      bit  long_run_done;
      sb = new();
      overflow_done = 1'b0;
      long_run_done = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: data before any key runs on the identity box
      send_item(OP_DATA, 8'h00, 1'b0, 1'b0);
      send_item(OP_DATA, 8'hff, 1'b1, 1'b0);   // last on data is ignored
      send_item(OP_DATA, 8'h5a, 1'b0, 1'b0);
      // single-byte keys at both extremes
      send_item(OP_KEY,  8'hff, 1'b1, 1'b0);
      send_item(OP_DATA, 8'h00, 1'b0, 1'b0);
      send_item(OP_DATA, 8'hff, 1'b0, 1'b0);
      send_item(OP_KEY,  8'h00, 1'b1, 1'b0);
      send_item(OP_DATA, 8'ha5, 1'b0, 1'b0);
      // short multi-byte key, back to back with the data after it
      send_item(OP_KEY,  8'h01, 1'b0, 1'b1);
      send_item(OP_KEY,  8'h80, 1'b0, 1'b1);
      send_item(OP_KEY,  8'h7f, 1'b1, 1'b1);
      send_item(OP_DATA, 8'hff, 1'b0, 1'b1);
      send_item(OP_DATA, 8'h00, 1'b0, 1'b1);
      send_item(OP_DATA, 8'h3c, 1'b1, 1'b0);

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 3) == 0);
         if (!overflow_done && items_sent - random_start > 150) begin
            // key overflow: bytes past the store depth are dropped, the
            // last mark sits on a dropped byte and still starts the schedule
            send_key(KEY_DEPTH_DEF + 2, burst);
            send_data($urandom_range(8, 20), burst);
            overflow_done = 1'b1;
         end else if (!long_run_done && items_sent - random_start > 450) begin
            // long data run: stream position wraps through zero
            send_key($urandom_range(1, 16), burst);
            send_data(270, burst);
            long_run_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
               // well-formed: new key, then a stream of data
               if ($urandom_range(0, 4) == 0) send_key($urandom_range(17, 40), burst);
               else send_key($urandom_range(1, 16), burst);
               send_data($urandom_range(4, 24), burst);
            end else if (pick == 7) begin
               // noise: any mix of op, value and last
               repeat ($urandom_range(1, 10))
                  send_item(1'($urandom), 8'($urandom), 1'($urandom), burst);
            end else if (pick == 8) begin
               // broken: key bytes with no last, data under the old box
               repeat ($urandom_range(1, 6))
                  send_item(OP_KEY, 8'($urandom), 1'b0, burst);
               send_data($urandom_range(1, 10), burst);
            end else begin
               send_data($urandom_range(1, 12), burst);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      // a trailing schedule may still be busy; any stray result shows up here
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.failures++;
         $display("%0d expected results never arrived", sb.pending());
      end

      $display("covered %0d key items (%0d dropped past depth), %0d data items, %0d schedules",
               sb.key_items, sb.dropped_keys, sb.data_items, sb.schedules);
      $display("%0d results checked, %0d failures", sb.checked, sb.failures);
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### rc4_variant_keybox_stream_decrypt.f
rtl/rc4kb_pkg.sv
rtl/rc4kb_box.sv
rtl/rc4_variant_keybox_stream_decrypt.sv
tb/testbench.sv
